// ===== rtl/dntp_pkg.sv =====
package dntp_pkg;

  // Accumulator sizing.
  localparam int unsigned INT_BITS    = 64;
  localparam int unsigned FRAC_DIGITS = 18;
  localparam int unsigned EXP_MAX     = 9999;

  // Fixed field widths of the result.
  localparam int unsigned INT_OUT_W = 64;
  localparam int unsigned FRAC_W    = 60;
  localparam int unsigned FLEN_W    = 5;
  localparam int unsigned EXP_W     = 14;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned DIGIT_W   = 4;

  // Request queue between the classifier and the parser core.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Character codes that steer the parse.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_LOW_E = 8'h65;
  localparam logic [CHAR_W-1:0] CHAR_UP_E  = 8'h45;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_MINUS,
    CLS_PLUS,
    CLS_POINT,
    CLS_EXP,
    CLS_OTHER
  } char_class_e;

  // One classified character as it travels from front to back.
  typedef struct packed {
    char_class_e            cls;
    logic [DIGIT_W-1:0]     digit;
    logic                   start;
  } char_req_t;

endpackage

// ===== rtl/dntp_front.sv =====
module dntp_front (
  input  logic [dntp_pkg::CHAR_W-1:0] char_code_i,
  input  logic                        start_req_i,
  output dntp_pkg::char_req_t         req_o
);

  logic [dntp_pkg::CHAR_W-1:0] offset;

  assign offset = char_code_i - dntp_pkg::CHAR_ZERO;

  always_comb begin
    req_o.start = start_req_i;
    req_o.digit = offset[dntp_pkg::DIGIT_W-1:0];
    if (char_code_i >= dntp_pkg::CHAR_ZERO && char_code_i <= dntp_pkg::CHAR_NINE) begin
      req_o.cls = dntp_pkg::CLS_DIGIT;
    end else if (char_code_i == dntp_pkg::CHAR_MINUS) begin
      req_o.cls = dntp_pkg::CLS_MINUS;
    end else if (char_code_i == dntp_pkg::CHAR_PLUS) begin
      req_o.cls = dntp_pkg::CLS_PLUS;
    end else if (char_code_i == dntp_pkg::CHAR_POINT) begin
      req_o.cls = dntp_pkg::CLS_POINT;
    end else if (char_code_i == dntp_pkg::CHAR_LOW_E || char_code_i == dntp_pkg::CHAR_UP_E) begin
      req_o.cls = dntp_pkg::CLS_EXP;
    end else begin
      req_o.cls = dntp_pkg::CLS_OTHER;
    end
  end

endmodule

// ===== rtl/dntp_queue.sv =====
module dntp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dntp_pkg::char_req_t push_req_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output dntp_pkg::char_req_t head_req_o
);

  dntp_pkg::char_req_t              entry_q [dntp_pkg::Q_DEPTH];
  logic [dntp_pkg::Q_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [dntp_pkg::Q_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [dntp_pkg::Q_CNT_W-1:0]     count_q, count_d;
  logic                             do_push, do_pop;

  assign full_o       = (count_q == dntp_pkg::Q_CNT_W'(dntp_pkg::Q_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_req_o   = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == dntp_pkg::Q_PTR_W'(dntp_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == dntp_pkg::Q_PTR_W'(dntp_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

// ===== rtl/dntp_back.sv =====
module dntp_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  input  dntp_pkg::char_req_t            req_i,
  output logic                           req_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           status_o,
  output logic                           negative_o,
  output logic [dntp_pkg::INT_OUT_W-1:0] integer_part_o,
  output logic [dntp_pkg::FRAC_W-1:0]    fraction_digits_o,
  output logic [dntp_pkg::FLEN_W-1:0]    fraction_count_o,
  output logic                           has_fraction_o,
  output logic                           exponent_negative_o,
  output logic [dntp_pkg::EXP_W-1:0]     exponent_value_o,
  output logic                           has_exponent_o,
  output logic                           saturated_o
);

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_INT,
    PH_ZERO,
    PH_FRAC,
    PH_ESIGN,
    PH_EDIG,
    PH_REJECT
  } phase_e;

  localparam int unsigned IntW  = dntp_pkg::INT_BITS;
  localparam int unsigned IntPW = dntp_pkg::INT_BITS + 4;
  localparam int unsigned ExpPW = dntp_pkg::EXP_W + 4;

  phase_e                             phase_q, phase_d, phase_c;
  logic                               neg_q, neg_d, neg_c;
  logic [IntW-1:0]                    int_q, int_d, int_c;
  logic [dntp_pkg::FRAC_W-1:0]        frac_q, frac_d, frac_c;
  logic [dntp_pkg::FLEN_W-1:0]        flen_q, flen_d, flen_c;
  logic                               point_q, point_d, point_c;
  logic                               eneg_q, eneg_d, eneg_c;
  logic [dntp_pkg::EXP_W-1:0]         exp_q, exp_d, exp_c;
  logic                               eseen_q, eseen_d, eseen_c;
  logic                               ovf_q, ovf_d, ovf_c;
  logic                               status_q, status_d;
  logic                               out_valid_q;
  logic                               take;
  logic                               is_digit;
  logic                               ok;
  logic [IntPW-1:0]                   int_prod;
  logic [ExpPW-1:0]                   exp_prod;
  logic [dntp_pkg::FRAC_W-1:0]        frac_prod;

  assign take      = !out_valid_q || !out_stall_i;
  assign req_pop_o = take && req_valid_i;
  assign is_digit  = (req_i.cls == dntp_pkg::CLS_DIGIT);

  // Start of a new number: parse from the reset state.
  always_comb begin
    if (req_i.start) begin
      phase_c = PH_WAIT;
      neg_c   = 1'b0;
      int_c   = '0;
      frac_c  = '0;
      flen_c  = '0;
      point_c = 1'b0;
      eneg_c  = 1'b0;
      exp_c   = '0;
      eseen_c = 1'b0;
      ovf_c   = 1'b0;
    end else begin
      phase_c = phase_q;
      neg_c   = neg_q;
      int_c   = int_q;
      frac_c  = frac_q;
      flen_c  = flen_q;
      point_c = point_q;
      eneg_c  = eneg_q;
      exp_c   = exp_q;
      eseen_c = eseen_q;
      ovf_c   = ovf_q;
    end
  end

  // Times-ten-plus-digit as shift-and-add; on the integer accumulator the wide top bits flag overflow.
  assign int_prod  = (IntPW'(int_c) << 3) + (IntPW'(int_c) << 1) + IntPW'(req_i.digit);
  assign exp_prod  = (ExpPW'(exp_c) << 3) + (ExpPW'(exp_c) << 1) + ExpPW'(req_i.digit);
  assign frac_prod = (frac_c << 3) + (frac_c << 1) + dntp_pkg::FRAC_W'(req_i.digit);

  always_comb begin
    phase_d = phase_c;
    neg_d   = neg_c;
    int_d   = int_c;
    frac_d  = frac_c;
    flen_d  = flen_c;
    point_d = point_c;
    eneg_d  = eneg_c;
    exp_d   = exp_c;
    eseen_d = eseen_c;
    ovf_d   = ovf_c;
    ok      = 1'b0;
    unique case (phase_c)
      PH_WAIT: begin
        if (req_i.cls == dntp_pkg::CLS_MINUS) begin
          neg_d = 1'b1;
          ok    = 1'b1;
        end else if (req_i.cls == dntp_pkg::CLS_PLUS) begin
          neg_d = 1'b0;
          ok    = 1'b1;
        end else if (is_digit && req_i.digit == '0) begin
          phase_d = PH_ZERO;
          ok      = 1'b1;
        end else if (is_digit) begin
          int_d   = IntW'(req_i.digit);
          phase_d = PH_INT;
          ok      = 1'b1;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          if (int_prod[IntPW-1 -: 4] != '0) begin
            int_d = '1;
            ovf_d = 1'b1;
          end else begin
            int_d = int_prod[IntW-1:0];
          end
          ok = 1'b1;
        end else if (req_i.cls == dntp_pkg::CLS_POINT) begin
          phase_d = PH_FRAC;
          flen_d  = '0;
          point_d = 1'b1;
          ok      = 1'b1;
        end else if (req_i.cls == dntp_pkg::CLS_EXP) begin
          phase_d = PH_ESIGN;
          ok      = 1'b1;
        end
      end
      PH_ZERO: begin
        if (req_i.cls == dntp_pkg::CLS_POINT) begin
          phase_d = PH_FRAC;
          flen_d  = '0;
          point_d = 1'b1;
          ok      = 1'b1;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          if (flen_c < dntp_pkg::FLEN_W'(dntp_pkg::FRAC_DIGITS)) begin
            frac_d = frac_prod;
            flen_d = flen_c + 1'b1;
          end
          ok = 1'b1;
        end else if (req_i.cls == dntp_pkg::CLS_EXP) begin
          phase_d = PH_ESIGN;
          ok      = 1'b1;
        end
      end
      PH_ESIGN: begin
        if (req_i.cls == dntp_pkg::CLS_MINUS || req_i.cls == dntp_pkg::CLS_PLUS) begin
          eneg_d  = (req_i.cls == dntp_pkg::CLS_MINUS);
          eseen_d = 1'b1;
          phase_d = PH_EDIG;
          ok      = 1'b1;
        end
      end
      PH_EDIG: begin
        if (is_digit) begin
          if (exp_prod > ExpPW'(dntp_pkg::EXP_MAX)) begin
            exp_d = dntp_pkg::EXP_W'(dntp_pkg::EXP_MAX);
            ovf_d = 1'b1;
          end else begin
            exp_d = exp_prod[dntp_pkg::EXP_W-1:0];
          end
          ok = 1'b1;
        end
      end
      PH_REJECT: begin
        ok = 1'b0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (!ok) begin
      phase_d = PH_REJECT;
    end
    status_d = !ok;
  end

  // The parse state doubles as the result register: it only moves when no
  // result is held or the held one is handed over, so a stalled result holds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      neg_q       <= 1'b0;
      int_q       <= '0;
      frac_q      <= '0;
      flen_q      <= '0;
      point_q     <= 1'b0;
      eneg_q      <= 1'b0;
      exp_q       <= '0;
      eseen_q     <= 1'b0;
      ovf_q       <= 1'b0;
      status_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= req_valid_i;
      if (req_valid_i) begin
        phase_q  <= phase_d;
        neg_q    <= neg_d;
        int_q    <= int_d;
        frac_q   <= frac_d;
        flen_q   <= flen_d;
        point_q  <= point_d;
        eneg_q   <= eneg_d;
        exp_q    <= exp_d;
        eseen_q  <= eseen_d;
        ovf_q    <= ovf_d;
        status_q <= status_d;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign negative_o          = neg_q;
  assign integer_part_o      = dntp_pkg::INT_OUT_W'(int_q);
  assign fraction_digits_o   = frac_q;
  assign fraction_count_o    = flen_q;
  assign has_fraction_o      = point_q;
  assign exponent_negative_o = eneg_q;
  assign exponent_value_o    = exp_q;
  assign has_exponent_o      = eseen_q;
  assign saturated_o         = ovf_q;

endmodule

// ===== rtl/decimal_number_text_parser.sv =====
// Decimal number text parser. Characters of a number literal enter one per
// cycle on the input channel while in_stall_o is low; start_req_i marks the
// first character of a new number and clears the parse state before it is
// used. Every request yields exactly one result: status_o is 0 when the
// character fits the grammar and 1 when it does not, and a rejection holds
// until the next start. The other result fields are the parts decoded so
// far: sign, saturating integer part, the first fraction digits as an integer
// with their count, and the saturating exponent with its sign. The block
// sustains one character per clock cycle while the result side keeps up; a
// request waits at the head of the request queue, and the parser core
// registers the result as it takes the request. The core's multiply-by-ten-
// and-add on the integer accumulator sets the critical path.
module decimal_number_text_parser (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Request channel: one character per request.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        start_req_i,

  // Result channel: one result per request.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic        negative_o,
  output logic [63:0] integer_part_o,
  output logic [59:0] fraction_digits_o,
  output logic [4:0]  fraction_count_o,
  output logic        has_fraction_o,
  output logic        exponent_negative_o,
  output logic [13:0] exponent_value_o,
  output logic        has_exponent_o,
  output logic        saturated_o
);

  dntp_pkg::char_req_t front_req;
  dntp_pkg::char_req_t head_req;
  logic                queue_full;
  logic                head_valid;
  logic                head_pop;

  // The front end sorts each character into a class and digit value so the
  // core only has to look at a few bits.
  dntp_front u_front (
    .char_code_i (char_code_i),
    .start_req_i (start_req_i),
    .req_o       (front_req)
  );

  // The short queue lets the input side keep accepting while a result waits
  // for the downstream side; the stall depends only on the fill level.
  assign in_stall_o = queue_full;

  dntp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_req_i   (front_req),
    .full_o       (queue_full),
    .pop_i        (head_pop),
    .head_valid_o (head_valid),
    .head_req_o   (head_req)
  );

  // The core walks the grammar and keeps the accumulators, which also form
  // the registered result.
  dntp_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .req_valid_i         (head_valid),
    .req_i               (head_req),
    .req_pop_o           (head_pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .negative_o          (negative_o),
    .integer_part_o      (integer_part_o),
    .fraction_digits_o   (fraction_digits_o),
    .fraction_count_o    (fraction_count_o),
    .has_fraction_o      (has_fraction_o),
    .exponent_negative_o (exponent_negative_o),
    .exponent_value_o    (exponent_value_o),
    .has_exponent_o      (has_exponent_o),
    .saturated_o         (saturated_o)
  );

endmodule

// ===== tb/decimal_number_text_parser_test.sv =====
`timescale 1ns / 100ps

module decimal_number_text_parser_test;

  // Requests queued before the run starts; the directed part comes first.
  localparam int DIRECTED_CHARS = 25;
  localparam int RANDOM_CHARS   = 1350;
  // Once fewer requests than this wait to be sent, neither side idles.
  localparam int QUIET_TAIL     = 150;
  // The receiver holds off once this many requests went in, for this long.
  localparam int HOLD_AFTER     = 400;
  localparam int HOLD_CYCLES    = 80;
  // Latency through the block, plus margin.
  localparam int DRAIN_CYCLES   = 10;
  localparam logic [63:0] INT_LIMIT = {64{1'b1}} >> (64 - dntp_pkg::INT_BITS);

  // Where the predictor stands in the literal grammar.
  typedef enum logic [2:0] {
    POS_LEAD,
    POS_INT,
    POS_ZERO,
    POS_FRAC,
    POS_EXP_SIGN,
    POS_EXP_DIG,
    POS_DEAD
  } grammar_pos_e;

  typedef struct {
    logic [7:0] ch;
    logic       first;
  } char_item_t;

  typedef struct packed {
    logic        status;
    logic        negative;
    logic [63:0] integer_part;
    logic [59:0] fraction_digits;
    logic [4:0]  fraction_count;
    logic        has_fraction;
    logic        exponent_negative;
    logic [13:0] exponent_value;
    logic        has_exponent;
    logic        saturated;
  } parse_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_code_i = 8'h00;
  logic        start_req_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        status_o;
  logic        negative_o;
  logic [63:0] integer_part_o;
  logic [59:0] fraction_digits_o;
  logic [4:0]  fraction_count_o;
  logic        has_fraction_o;
  logic        exponent_negative_o;
  logic [13:0] exponent_value_o;
  logic        has_exponent_o;
  logic        saturated_o;

  // Predictor state, mirroring the parse state held inside the block.
  grammar_pos_e grammar_pos;
  logic         mant_negative;
  logic [63:0]  int_acc;
  logic [59:0]  frac_acc;
  logic [4:0]   frac_len;
  logic         point_seen;
  logic         exp_negative;
  logic [13:0]  exp_acc;
  logic         exp_seen;
  logic         overflowed;

  char_item_t    pending_chars[$];
  parse_result_t expected_results[$];

  int  accepted_count = 0;
  int  result_count = 0;
  int  mismatch_count = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  bit  send_bursty = 1'b1;
  bit  recv_bursty = 1'b1;
  logic hold_off = 1'b0;

  decimal_number_text_parser uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .char_code_i         (char_code_i),
    .start_req_i         (start_req_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .negative_o          (negative_o),
    .integer_part_o      (integer_part_o),
    .fraction_digits_o   (fraction_digits_o),
    .fraction_count_o    (fraction_count_o),
    .has_fraction_o      (has_fraction_o),
    .exponent_negative_o (exponent_negative_o),
    .exponent_value_o    (exponent_value_o),
    .has_exponent_o      (has_exponent_o),
    .saturated_o         (saturated_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Returns the parse state to its value after reset.
  function automatic void clear_parse();
    grammar_pos   = POS_LEAD;
    mant_negative = 1'b0;
    int_acc       = '0;
    frac_acc      = '0;
    frac_len      = '0;
    point_seen    = 1'b0;
    exp_negative  = 1'b0;
    exp_acc       = '0;
    exp_seen      = 1'b0;
    overflowed    = 1'b0;
  endfunction

  // Advances the predicted parse by one accepted character and queues the
  // result the block has to answer with.
  function automatic void predict_char(input logic [7:0] ch, input logic restart);
    logic          is_digit;
    logic          is_exp;
    logic          ok;
    logic [3:0]    digit;
    logic [31:0]   next_exp;
    parse_result_t r;
    if (restart) clear_parse();
    is_digit = (ch >= dntp_pkg::CHAR_ZERO) && (ch <= dntp_pkg::CHAR_NINE);
    digit    = is_digit ? 4'(ch - dntp_pkg::CHAR_ZERO) : 4'd0;
    is_exp   = (ch == dntp_pkg::CHAR_LOW_E) || (ch == dntp_pkg::CHAR_UP_E);
    ok       = 1'b1;
    case (grammar_pos)
      POS_LEAD: begin
        // Any run of signs may lead; the last one wins.
        if (ch == dntp_pkg::CHAR_MINUS) mant_negative = 1'b1;
        else if (ch == dntp_pkg::CHAR_PLUS) mant_negative = 1'b0;
        else if (ch == dntp_pkg::CHAR_ZERO) grammar_pos = POS_ZERO;
        else if (is_digit) begin
          int_acc     = 64'(digit);
          grammar_pos = POS_INT;
        end else ok = 1'b0;
      end
      POS_INT: begin
        if (is_digit) begin
          // Saturate rather than wrap once another digit would not fit.
          if (int_acc > (INT_LIMIT - 64'(digit)) / 64'd10) begin
            int_acc    = INT_LIMIT;
            overflowed = 1'b1;
          end else begin
            int_acc = int_acc * 64'd10 + 64'(digit);
          end
        end else if (ch == dntp_pkg::CHAR_POINT) begin
          grammar_pos = POS_FRAC;
          frac_len    = '0;
          point_seen  = 1'b1;
        end else if (is_exp) grammar_pos = POS_EXP_SIGN;
        else ok = 1'b0;
      end
      POS_ZERO: begin
        // A lone leading zero may only be followed by the decimal point.
        if (ch == dntp_pkg::CHAR_POINT) begin
          grammar_pos = POS_FRAC;
          frac_len    = '0;
          point_seen  = 1'b1;
        end else ok = 1'b0;
      end
      POS_FRAC: begin
        if (is_digit) begin
          // Digits past the kept count are accepted but dropped.
          if (frac_len < dntp_pkg::FRAC_DIGITS) begin
            frac_acc = frac_acc * 60'd10 + 60'(digit);
            frac_len = frac_len + 5'd1;
          end
        end else if (is_exp) grammar_pos = POS_EXP_SIGN;
        else ok = 1'b0;
      end
      POS_EXP_SIGN: begin
        // The exponent sign is mandatory.
        if (ch == dntp_pkg::CHAR_MINUS || ch == dntp_pkg::CHAR_PLUS) begin
          exp_negative = (ch == dntp_pkg::CHAR_MINUS);
          exp_seen     = 1'b1;
          grammar_pos  = POS_EXP_DIG;
        end else ok = 1'b0;
      end
      POS_EXP_DIG: begin
        if (is_digit) begin
          next_exp = 32'(exp_acc) * 32'd10 + 32'(digit);
          if (next_exp > dntp_pkg::EXP_MAX) begin
            exp_acc    = 14'(dntp_pkg::EXP_MAX);
            overflowed = 1'b1;
          end else begin
            exp_acc = 14'(next_exp);
          end
        end else ok = 1'b0;
      end
      default: ok = 1'b0;
    endcase
    // A rejection sticks until the next start.
    if (!ok) grammar_pos = POS_DEAD;

    r.status            = !ok;
    r.negative          = mant_negative;
    r.integer_part      = int_acc;
    r.fraction_digits   = frac_acc;
    r.fraction_count    = frac_len;
    r.has_fraction      = point_seen;
    r.exponent_negative = exp_negative;
    r.exponent_value    = exp_acc;
    r.has_exponent      = exp_seen;
    r.saturated         = overflowed;
    expected_results.push_back(r);
  endfunction

  function automatic string show_result(input parse_result_t r);
    return $sformatf("st=%0b neg=%0b int=%0d frac=%0d cnt=%0d pt=%0b eneg=%0b exp=%0d es=%0b sat=%0b",
                     r.status, r.negative, r.integer_part, r.fraction_digits,
                     r.fraction_count, r.has_fraction, r.exponent_negative,
                     r.exponent_value, r.has_exponent, r.saturated);
  endfunction

  function automatic void add_char(input logic [7:0] ch, input logic first);
    char_item_t item;
    item.ch    = ch;
    item.first = first;
    pending_chars.push_back(item);
  endfunction

  // Queues a string of characters; only the first may carry a start.
  function automatic void add_text(input string s, input logic restart);
    for (int i = 0; i < s.len(); i++) add_char(s[i], (i == 0) ? restart : 1'b0);
  endfunction

  // Request driver. The prediction is made at the edge where a request is
  // taken, so it always sees the characters in the order the block does.
  // A held request is never changed or withdrawn; idle bursts only start
  // once the channel is free.
  always @(posedge clk_i) begin
    char_item_t item;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_char(char_code_i, start_req_i);
        accepted_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if ($urandom_range(0, 199) == 0) send_bursty = !send_bursty;
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_chars.size() > QUIET_TAIL && send_bursty && !hold_off &&
                     $urandom_range(0, 5) == 0) begin
          // This cycle counts as the first of the burst.
          send_gap = $urandom_range(0, 10);
          in_valid_i <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          item = pending_chars.pop_front();
          in_valid_i  <= 1'b1;
          char_code_i <= item.ch;
          start_req_i <= item.first;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every result taken is checked against the oldest
  // prediction; the receiver stalls in random bursts and during the hold-off.
  always @(posedge clk_i) begin
    parse_result_t got;
    parse_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{status_o, negative_o, integer_part_o, fraction_digits_o,
                fraction_count_o, has_fraction_o, exponent_negative_o,
                exponent_value_o, has_exponent_o, saturated_o};
        result_count++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d arrived with no request waiting: %s",
                     result_count, show_result(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result %0d mismatch", result_count);
              $display("  expected %s", show_result(want));
              $display("  actual   %s", show_result(got));
            end
          end
        end
      end
      if ($urandom_range(0, 199) == 0) recv_bursty = !recv_bursty;
      if (recv_gap != 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (pending_chars.size() > QUIET_TAIL && recv_bursty &&
                   $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // A long receiver hold-off while the sender keeps offering requests, so
  // the internal queue fills and the block has to stall its input.
  initial begin
    wait (accepted_count >= HOLD_AFTER);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [7:0] txt[$];
    int         len;
    int         pos;
    clear_parse();

    // Directed part. The first literal runs without a start, straight from
    // reset: several signs, a lone zero, an empty fraction, an upper-case
    // exponent mark and an empty exponent.
    add_text("-+-0.E-", 1'b0);
    // Fraction and an exponent that saturates on its fifth digit.
    add_text("7.5e+99999", 1'b1);
    // A digit after a lone zero is rejected, and the rejection sticks.
    add_text("07", 1'b1);
    add_char(8'hFF, 1'b0);
    add_char(8'h00, 1'b1);
    // Exponent mark with no mantissa, then an exponent missing its sign.
    add_text("e", 1'b1);
    add_text("1e5", 1'b1);

    // Random part: mostly well-formed literals with random content and
    // lengths, some corrupted, plus runs of raw noise bytes.
    while (pending_chars.size() < DIRECTED_CHARS + RANDOM_CHARS) begin
      txt.delete();
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 3) * $urandom_range(0, 1))
          txt.push_back($urandom_range(0, 1) ? dntp_pkg::CHAR_MINUS : dntp_pkg::CHAR_PLUS);
        if ($urandom_range(0, 6) == 0) begin
          txt.push_back(dntp_pkg::CHAR_ZERO);
        end else begin
          // Now and then a long integer, which may saturate.
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 23) : $urandom_range(1, 6);
          txt.push_back(8'(dntp_pkg::CHAR_ZERO + $urandom_range(1, 9)));
          repeat (len - 1) txt.push_back(8'(dntp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
        end
        if (txt[txt.size() - 1] == dntp_pkg::CHAR_ZERO && txt.size() == 1 ||
            $urandom_range(0, 1)) begin
          // Now and then a long fraction, at times with more digits than are kept.
          txt.push_back(dntp_pkg::CHAR_POINT);
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 24) : $urandom_range(0, 5);
          repeat (len) txt.push_back(8'(dntp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 4) < 2) begin
          txt.push_back($urandom_range(0, 1) ? dntp_pkg::CHAR_LOW_E : dntp_pkg::CHAR_UP_E);
          txt.push_back($urandom_range(0, 1) ? dntp_pkg::CHAR_MINUS : dntp_pkg::CHAR_PLUS);
          repeat ($urandom_range(0, 5))
            txt.push_back(8'(dntp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 6) == 0) begin
          pos = $urandom_range(0, txt.size() - 1);
          txt[pos] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 9) == 0) txt.push_back(8'($urandom_range(0, 255)));
      end
      // Usually a start on the first character; rarely none, or one in the
      // middle of a literal.
      foreach (txt[i])
        add_char(txt[i], (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0));
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_chars.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
